[rtl/sstf_pkg.sv]
`default_nettype none

package sstf_pkg;

  localparam int CYL_W      = 16;
  localparam int SUM_W      = 22;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  typedef logic [CYL_W-1:0] cyl_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = '1;

  typedef struct packed {
    logic clear;
    logic sample;
  } pick_ctl_t;

  typedef struct packed {
    logic found;
    cyl_t seek;
    cyl_t cyl;
  } pick_res_t;

endpackage

`default_nettype wire

[rtl/sstf_store.sv]
`default_nettype none

module sstf_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire sstf_pkg::cyl_t    wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output sstf_pkg::cyl_t         rd_data
);
  import sstf_pkg::*;

  cyl_t mem [DEPTH];
  cyl_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/sstf_pick.sv]
`default_nettype none

module sstf_pick #(
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sstf_pkg::pick_ctl_t ctl,
  input  wire sstf_pkg::cyl_t   head,
  input  wire sstf_pkg::cyl_t   cyl,
  input  wire logic [IDX_W-1:0] idx,
  output sstf_pkg::pick_res_t   res,
  output logic [IDX_W-1:0]      best_idx
);
  import sstf_pkg::*;

  logic             found_r, found_nxt;
  cyl_t             dist_r, dist_nxt;
  cyl_t             cyl_r, cyl_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  cyl_t             seek;
  logic             better;

  // one distance unit, strict compare keeps the earliest index on a tie
  assign seek   = (head >= cyl) ? (head - cyl) : (cyl - head);
  assign better = ctl.sample && (!found_r || (seek < dist_r));

  always_comb begin
    found_nxt = found_r;
    dist_nxt  = dist_r;
    cyl_nxt   = cyl_r;
    idx_nxt   = idx_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (better) begin
      found_nxt = 1'b1;
      dist_nxt  = seek;
      cyl_nxt   = cyl;
      idx_nxt   = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    dist_r <= dist_nxt;
    cyl_r  <= cyl_nxt;
    idx_r  <= idx_nxt;
  end

  assign res.found = found_r;
  assign res.seek  = dist_r;
  assign res.cyl   = cyl_r;
  assign best_idx  = idx_r;

endmodule

`default_nettype wire

[rtl/shortest_seek_first_scheduler.sv]
// Shortest-seek-first scheduler. Requests are loaded one item per cycle into a
// request memory of MAX_REQUESTS entries; extras are dropped and flag overflow on
// every result of the batch. The item with in_tlast set starts the schedule from
// the start_head register. Each of the n picks sweeps the n stored requests through
// one distance comparator, one memory read per cycle; each result then waits on
// out_tready before the next sweep starts. The block takes no new request until
// the last result of the batch is taken. Ties in distance go to the request
// loaded first.
`default_nettype none

module shortest_seek_first_scheduler #(
  parameter int MAX_REQUESTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [15:0]                   cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sstf_pkg::IN_DATA_W-1:0] in_tdata,   // request_cylinder
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // served_cylinder, seek_distance, total_movement, zero pad
  output logic [sstf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser     // overflow
);
  import sstf_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_STEP,
    S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        issue_r, issue_nxt;
  logic [CNT_W-1:0]        picks_r, picks_nxt;
  cyl_t                    head_r, head_nxt;
  sum_t                    sum_r, sum_nxt;
  logic                    dropped_r, dropped_nxt;
  logic [MAX_REQUESTS-1:0] mask_r, mask_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  cyl_t                    start_head_r;
  logic                    out_vld_r, out_vld_nxt;
  cyl_t                    out_cyl_r, out_cyl_nxt;
  cyl_t                    out_dist_r, out_dist_nxt;
  sum_t                    out_sum_r, out_sum_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic             wr_en, rd_en;
  cyl_t             rd_data;
  pick_ctl_t        pick_ctl;
  pick_res_t        pick_res;
  logic [IDX_W-1:0] best_idx;
  logic             in_acc;
  logic [SUM_W:0]   sum_ext;
  logic [CNT_W-1:0] picks_inc;

  sstf_store #(
    .DEPTH  (MAX_REQUESTS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_tdata[CYL_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  sstf_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .head     (head_r),
    .cyl      (rd_data),
    .idx      (rd_idx_r),
    .res      (pick_res),
    .best_idx (best_idx)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign sum_ext   = {1'b0, sum_r} + (SUM_W + 1)'(pick_res.seek);
  assign picks_inc = picks_r + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    picks_nxt    = picks_r;
    head_nxt     = head_r;
    sum_nxt      = sum_r;
    dropped_nxt  = dropped_r;
    mask_nxt     = mask_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    out_vld_nxt  = out_vld_r;
    out_cyl_nxt  = out_cyl_r;
    out_dist_nxt = out_dist_r;
    out_sum_nxt  = out_sum_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    in_tready    = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    pick_ctl.clear  = 1'b0;
    pick_ctl.sample = rd_vld_r && !mask_r[rd_idx_r];
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (count_r < CNT_MAX) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_tlast) begin
            head_nxt       = start_head_r;
            sum_nxt        = '0;
            issue_nxt      = '0;
            picks_nxt      = '0;
            pick_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = issue_r < count_r;
        if (rd_en) begin
          issue_nxt  = issue_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[IDX_W-1:0];
        end else if (!rd_vld_r) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mask_nxt[best_idx] = 1'b1;
        head_nxt     = pick_res.cyl;
        sum_nxt      = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        picks_nxt    = picks_inc;
        out_vld_nxt  = 1'b1;
        out_cyl_nxt  = pick_res.cyl;
        out_dist_nxt = pick_res.seek;
        out_sum_nxt  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        out_last_nxt = picks_inc == count_r;
        out_ovf_nxt  = dropped_r;
        pick_ctl.clear = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_vld_nxt = 1'b0;
          if (picks_r == count_r) begin
            count_nxt   = '0;
            mask_nxt    = '0;
            dropped_nxt = 1'b0;
            sum_nxt     = '0;
            picks_nxt   = '0;
            state_nxt   = S_LOAD;
          end else begin
            issue_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      count_r      <= '0;
      issue_r      <= '0;
      picks_r      <= '0;
      head_r       <= '0;
      sum_r        <= '0;
      dropped_r    <= 1'b0;
      mask_r       <= '0;
      rd_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      start_head_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      issue_r   <= issue_nxt;
      picks_r   <= picks_nxt;
      head_r    <= head_nxt;
      sum_r     <= sum_nxt;
      dropped_r <= dropped_nxt;
      mask_r    <= mask_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        start_head_r <= cfg_wr_data[CYL_W-1:0];
      end
    end
    rd_idx_r   <= rd_idx_nxt;
    out_cyl_r  <= out_cyl_nxt;
    out_dist_r <= out_dist_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_sum_r, out_dist_r, out_cyl_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_MAX) && (picks_r <= count_r))
    else $error("request or pick count out of range");

  a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> (count_r == '0) && (mask_r == '0))
    else $error("batch state not cleared after last result");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> pick_res.found)
    else $error("pick step with no unserved request");

endmodule

`default_nettype wire
